[src/fpsm_pkg.sv]
// Shared constants, codes and binary16 arithmetic functions for the packed symmetric matvec.
`timescale 1ns / 1ps
package fpsm_pkg;

    localparam int MAX_ORDER_DEF = 64;
    localparam int INDEX_W       = 12;
    localparam int RIDX_W        = 6;
    localparam int ORDER_W       = 7;
    localparam int CFG_IDX_W     = 2;

    localparam logic [15:0] HALF_ONE  = 16'h3C00;
    localparam logic [15:0] HALF_QNAN = 16'h7E00;
    localparam logic [14:0] HALF_INF  = 15'h7C00;

    localparam logic [1:0] MODE_LOAD_X = 2'd0;
    localparam logic [1:0] MODE_LOAD_Y = 2'd1;
    localparam logic [1:0] MODE_LOAD_A = 2'd2;
    localparam logic [1:0] MODE_RUN    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_TRIANGLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BETA     = 2'd3;

    // Rounds the exact value m * 2^e to binary16, nearest even. m must be nonzero.
    function automatic logic [15:0] round_pack(input logic sgn, input logic [23:0] m,
                                               input int e);
        int          p;
        int          ue;
        int          sh;
        logic [31:0] mm;
        logic [31:0] q;
        logic [31:0] rem;
        logic [31:0] half;
        logic [31:0] enc;
        logic        up;
        p    = 0;
        up   = 1'b0;
        rem  = 32'd0;
        half = 32'd0;
        for (int b = 0; b < 24; b++)
        begin
            if (m[b])
            begin
                p = b;
            end
        end
        ue = p + e;
        mm = {8'd0, m};
        if (ue >= 16)
        begin
            return {sgn, HALF_INF};
        end
        sh = (ue >= -14) ? p - 10 : -24 - e;
        if (sh >= 24)
        begin
            return {sgn, 15'd0};
        end
        if (sh <= 0)
        begin
            q = mm << (-sh);
        end
        else
        begin
            q    = mm >> sh;
            rem  = mm & ((32'd1 << sh) - 32'd1);
            half = 32'd1 << (sh - 1);
            up   = (rem > half) || ((rem == half) && q[0]);
        end
        enc = ((ue >= -14) ? (32'(ue + 14) << 10) : 32'd0) + q + {31'd0, up};
        return {sgn, enc[14:0]};
    endfunction

    function automatic logic [15:0] hmul(input logic [15:0] a, input logic [15:0] b);
        logic        s;
        logic        a_nan;
        logic        b_nan;
        logic        a_inf;
        logic        b_inf;
        logic        a_zero;
        logic        b_zero;
        logic [10:0] ma;
        logic [10:0] mb;
        logic [4:0]  ea;
        logic [4:0]  eb;
        logic [21:0] p;
        s      = a[15] ^ b[15];
        a_nan  = (&a[14:10]) && (|a[9:0]);
        b_nan  = (&b[14:10]) && (|b[9:0]);
        a_inf  = (&a[14:10]) && !(|a[9:0]);
        b_inf  = (&b[14:10]) && !(|b[9:0]);
        a_zero = (a[14:0] == 15'd0);
        b_zero = (b[14:0] == 15'd0);
        if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero))
        begin
            return HALF_QNAN;
        end
        if (a_inf || b_inf)
        begin
            return {s, HALF_INF};
        end
        if (a_zero || b_zero)
        begin
            return {s, 15'd0};
        end
        ma = {|a[14:10], a[9:0]};
        mb = {|b[14:10], b[9:0]};
        ea = (a[14:10] == 5'd0) ? 5'd1 : a[14:10];
        eb = (b[14:10] == 5'd0) ? 5'd1 : b[14:10];
        p  = 22'(ma * mb);
        return round_pack(s, {2'd0, p}, int'(ea) + int'(eb) - 50);
    endfunction

    function automatic logic [15:0] hadd(input logic [15:0] a, input logic [15:0] b);
        logic        a_nan;
        logic        b_nan;
        logic        a_inf;
        logic        b_inf;
        logic [15:0] lg;
        logic [15:0] sm;
        logic [10:0] ml;
        logic [10:0] ms;
        logic [4:0]  el;
        logic [4:0]  es;
        logic [4:0]  d;
        logic [13:0] lx;
        logic [13:0] sx;
        logic [13:0] al;
        logic        st;
        logic [14:0] r;
        a_nan = (&a[14:10]) && (|a[9:0]);
        b_nan = (&b[14:10]) && (|b[9:0]);
        a_inf = (&a[14:10]) && !(|a[9:0]);
        b_inf = (&b[14:10]) && !(|b[9:0]);
        if (a_nan || b_nan || (a_inf && b_inf && (a[15] != b[15])))
        begin
            return HALF_QNAN;
        end
        if (a_inf)
        begin
            return {a[15], HALF_INF};
        end
        if (b_inf)
        begin
            return {b[15], HALF_INF};
        end
        if ((a[14:0] == 15'd0) && (b[14:0] == 15'd0))
        begin
            return {a[15] & b[15], 15'd0};
        end
        if (a[14:0] == 15'd0)
        begin
            return b;
        end
        if (b[14:0] == 15'd0)
        begin
            return a;
        end
        if (a[14:0] >= b[14:0])
        begin
            lg = a;
            sm = b;
        end
        else
        begin
            lg = b;
            sm = a;
        end
        ml = {|lg[14:10], lg[9:0]};
        ms = {|sm[14:10], sm[9:0]};
        el = (lg[14:10] == 5'd0) ? 5'd1 : lg[14:10];
        es = (sm[14:10] == 5'd0) ? 5'd1 : sm[14:10];
        d  = el - es;
        lx = {ml, 3'd0};
        sx = {ms, 3'd0};
        // Bits shifted out below the guard positions collapse into one sticky bit.
        if (d >= 5'd14)
        begin
            al = 14'd0;
            st = 1'b1;
        end
        else
        begin
            al = sx >> d;
            st = |(sx & ((14'd1 << d) - 14'd1));
        end
        al[0] = al[0] | st;
        if (lg[15] == sm[15])
        begin
            r = {1'b0, lx} + {1'b0, al};
        end
        else
        begin
            r = {1'b0, lx} - {1'b0, al};
        end
        if (r == 15'd0)
        begin
            return 16'h0000;
        end
        return round_pack(lg[15], {9'd0, r}, int'(el) - 28);
    endfunction

endpackage

[src/fpsm_channels.sv]
// Handshake channel interfaces for items, results and register writes.
`timescale 1ns / 1ps
interface fpsm_item_if;
    import fpsm_pkg::*;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [INDEX_W-1:0] index;
    logic [15:0]        value_bits;
    modport source (output valid, mode, index, value_bits, input ready);
    modport sink (input valid, mode, index, value_bits, output ready);
endinterface

interface fpsm_result_if;
    import fpsm_pkg::*;
    logic              valid;
    logic              ready;
    logic [RIDX_W-1:0] result_index;
    logic [15:0]       result_bits;
    logic              last;
    modport source (output valid, result_index, result_bits, last, input ready);
    modport sink (input valid, result_index, result_bits, last, output ready);
endinterface

interface fpsm_cfg_if;
    import fpsm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [15:0]          data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[src/fp16_packed_symmetric_matvec.sv]
// Packed symmetric matrix-vector multiply y = alpha*A*x + beta*y in binary16.
// Load beats are accepted only while idle. A run goes through a beta pass (when beta is not one),
// column sweeps (when alpha is nonzero) and a read-out, stepped by the sequencer over
// one shared multiplier and adder; no new beat is taken meanwhile.
// Reset (async, active low) clears control and registers; x, y and matrix stores are
// undefined until loaded.
`timescale 1ns / 1ps
module fp16_packed_symmetric_matvec #(
    parameter int MAX_ORDER = fpsm_pkg::MAX_ORDER_DEF
) (
    input logic           clk,
    input logic           rst_n,
    fpsm_item_if.sink     item,
    fpsm_result_if.source result,
    fpsm_cfg_if.sink      cfg
);
    import fpsm_pkg::*;

    localparam int XAW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int XCW = $clog2(MAX_ORDER + 1);
    localparam int PD  = MAX_ORDER * (MAX_ORDER + 1) / 2;
    localparam int PAW = (PD > 1) ? $clog2(PD) : 1;
    localparam int PCW = $clog2(PD + 1);
    localparam logic [XCW-1:0] ONE_X = XCW'(1);
    localparam logic [PCW-1:0] ONE_P = PCW'(1);

    typedef enum logic [3:0] {
        S_IDLE, S_BRD, S_BWR, S_CRD, S_CSX, S_DM, S_DA, S_LRD,
        S_LM1, S_LA1, S_LM2, S_LA2, S_FM, S_FA, S_ORD, S_OUT
    } state_t;

    state_t               state_reg;
    logic                 triangle_reg;
    logic [ORDER_W-1:0]   order_reg;
    logic [15:0]          alpha_reg;
    logic [15:0]          beta_reg;
    logic [XCW-1:0]       n_reg;
    logic [XCW-1:0]       i_reg;
    logic [XCW-1:0]       j_reg;
    logic [PCW-1:0]       k_reg;
    logic [PCW-1:0]       kk_reg;
    logic [15:0]          csx_reg;
    logic [15:0]          dot_reg;
    logic [15:0]          tmp_reg;
    logic [15:0]          prod_reg;
    logic                 out_valid_reg;
    logic [RIDX_W-1:0]    out_index_reg;
    logic [15:0]          out_bits_reg;
    logic                 out_last_reg;

    logic [15:0] x_mem [MAX_ORDER];
    logic [15:0] y_mem [MAX_ORDER];
    logic [15:0] ap_mem [PD];
    logic [15:0] x_rd_reg;
    logic [15:0] y_rd_reg;
    logic [15:0] ap_rd_reg;

    logic [XAW-1:0] x_ra;
    logic [XAW-1:0] y_ra;
    logic [PAW-1:0] ap_ra;
    logic           x_we;
    logic           y_we;
    logic           ap_we;
    logic [XAW-1:0] y_wa;
    logic [15:0]    y_wd;
    logic [15:0]    mul_a;
    logic [15:0]    mul_b;
    logic [15:0]    add_a;
    logic [15:0]    add_b;
    logic [15:0]    mul_res;
    logic [15:0]    add_res;
    logic           accept;
    logic           x_in_range;
    logic           ap_in_range;
    logic           alpha_zero;
    logic           beta_zero;
    logic           can_load;
    logic [XCW-1:0] n_cfg;
    logic [XCW-1:0] loop_end;
    logic [PCW-1:0] diag_addr;

    assign item.ready    = (state_reg == S_IDLE);
    assign cfg.ready     = 1'b1;
    assign accept        = item.valid && item.ready;
    assign x_in_range    = item.index < INDEX_W'(MAX_ORDER);
    assign ap_in_range   = item.index < INDEX_W'(PD);
    assign alpha_zero    = (alpha_reg[14:0] == 15'd0);
    assign beta_zero     = (beta_reg[14:0] == 15'd0);
    assign n_cfg         = (order_reg > ORDER_W'(MAX_ORDER)) ? XCW'(MAX_ORDER)
                                                             : XCW'(order_reg);
    assign loop_end      = triangle_reg ? n_reg : j_reg;
    assign diag_addr     = triangle_reg ? kk_reg : kk_reg + PCW'(j_reg);
    assign can_load      = !out_valid_reg || result.ready;
    assign mul_res       = hmul(mul_a, mul_b);
    assign add_res       = hadd(add_a, add_b);

    assign result.valid        = out_valid_reg;
    assign result.result_index = out_index_reg;
    assign result.result_bits  = out_bits_reg;
    assign result.last         = out_last_reg;

    // Operand and memory port selection for the shared multiplier and adder.
    // Read addresses are held through a sweep step so the registered data stays put.
    always_comb
    begin
        x_ra  = j_reg[XAW-1:0];
        y_ra  = j_reg[XAW-1:0];
        ap_ra = diag_addr[PAW-1:0];
        mul_a = alpha_reg;
        mul_b = x_rd_reg;
        add_a = tmp_reg;
        add_b = prod_reg;
        x_we  = accept && (item.mode == MODE_LOAD_X) && x_in_range;
        ap_we = accept && (item.mode == MODE_LOAD_A) && ap_in_range;
        y_we  = accept && (item.mode == MODE_LOAD_Y) && x_in_range;
        y_wa  = item.index[XAW-1:0];
        y_wd  = item.value_bits;
        case (state_reg)
            S_BRD:
            begin
                y_ra = i_reg[XAW-1:0];
            end
            S_BWR:
            begin
                mul_a = beta_reg;
                mul_b = y_rd_reg;
                y_we  = 1'b1;
                y_wa  = i_reg[XAW-1:0];
                y_wd  = beta_zero ? 16'h0000 : mul_res;
            end
            S_DM:
            begin
                mul_a = csx_reg;
                mul_b = ap_rd_reg;
            end
            S_LM1:
            begin
                x_ra  = i_reg[XAW-1:0];
                y_ra  = i_reg[XAW-1:0];
                ap_ra = k_reg[PAW-1:0];
                mul_a = csx_reg;
                mul_b = ap_rd_reg;
            end
            S_DA:
            begin
                add_a = y_rd_reg;
            end
            S_LRD:
            begin
                x_ra  = i_reg[XAW-1:0];
                y_ra  = i_reg[XAW-1:0];
                ap_ra = k_reg[PAW-1:0];
            end
            S_LA1:
            begin
                x_ra  = i_reg[XAW-1:0];
                y_ra  = i_reg[XAW-1:0];
                ap_ra = k_reg[PAW-1:0];
                add_a = y_rd_reg;
                y_we  = 1'b1;
                y_wa  = i_reg[XAW-1:0];
                y_wd  = add_res;
            end
            S_LM2:
            begin
                mul_a = ap_rd_reg;
            end
            S_LA2:
            begin
                add_a = dot_reg;
            end
            S_FM:
            begin
                mul_b = dot_reg;
            end
            S_FA:
            begin
                y_we = 1'b1;
                y_wa = j_reg[XAW-1:0];
                y_wd = add_res;
            end
            S_ORD, S_OUT:
            begin
                y_ra = i_reg[XAW-1:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (x_we)
        begin
            x_mem[item.index[XAW-1:0]] <= item.value_bits;
        end
        if (ap_we)
        begin
            ap_mem[item.index[PAW-1:0]] <= item.value_bits;
        end
        if (y_we)
        begin
            y_mem[y_wa] <= y_wd;
        end
        x_rd_reg  <= x_mem[x_ra];
        y_rd_reg  <= y_mem[y_ra];
        ap_rd_reg <= ap_mem[ap_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            triangle_reg  <= 1'b0;
            order_reg     <= '0;
            alpha_reg     <= 16'h0000;
            beta_reg      <= HALF_ONE;
            n_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            kk_reg        <= '0;
            csx_reg       <= 16'h0000;
            dot_reg       <= 16'h0000;
            tmp_reg       <= 16'h0000;
            prod_reg      <= 16'h0000;
            out_valid_reg <= 1'b0;
            out_index_reg <= '0;
            out_bits_reg  <= 16'h0000;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_TRIANGLE: triangle_reg <= cfg.data[0];
                    REG_ORDER:    order_reg    <= cfg.data[ORDER_W-1:0];
                    REG_ALPHA:    alpha_reg    <= cfg.data;
                    REG_BETA:     beta_reg     <= cfg.data;
                    default:
                    begin
                    end
                endcase
            end
            if (result.ready && !((state_reg == S_OUT) && can_load))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    i_reg  <= '0;
                    j_reg  <= '0;
                    kk_reg <= '0;
                    if (accept && (item.mode == MODE_RUN) && (n_cfg != '0))
                    begin
                        n_reg <= n_cfg;
                        if (beta_reg != HALF_ONE)
                        begin
                            state_reg <= S_BRD;
                        end
                        else if (alpha_zero)
                        begin
                            state_reg <= S_ORD;
                        end
                        else
                        begin
                            state_reg <= S_CRD;
                        end
                    end
                end
                S_BRD:
                begin
                    state_reg <= S_BWR;
                end
                S_BWR:
                begin
                    if (i_reg + ONE_X == n_reg)
                    begin
                        i_reg     <= '0;
                        state_reg <= alpha_zero ? S_ORD : S_CRD;
                    end
                    else
                    begin
                        i_reg     <= i_reg + ONE_X;
                        state_reg <= S_BRD;
                    end
                end
                S_CRD:
                begin
                    state_reg <= S_CSX;
                end
                S_CSX:
                begin
                    csx_reg   <= mul_res;
                    state_reg <= S_DM;
                end
                S_DM, S_LM1, S_LM2, S_FM:
                begin
                    prod_reg <= mul_res;
                    case (state_reg)
                        S_DM:    state_reg <= S_DA;
                        S_LM1:   state_reg <= S_LA1;
                        S_LM2:   state_reg <= S_LA2;
                        default: state_reg <= S_FA;
                    endcase
                end
                S_DA:
                begin
                    // The diagonal term is held aside; the sweep below never touches y[j].
                    tmp_reg <= add_res;
                    dot_reg <= 16'h0000;
                    if (!triangle_reg)
                    begin
                        i_reg     <= '0;
                        k_reg     <= kk_reg;
                        state_reg <= (j_reg == '0) ? S_FM : S_LRD;
                    end
                    else
                    begin
                        i_reg     <= j_reg + ONE_X;
                        k_reg     <= kk_reg + ONE_P;
                        state_reg <= (j_reg + ONE_X == n_reg) ? S_FM : S_LRD;
                    end
                end
                S_LRD:
                begin
                    state_reg <= S_LM1;
                end
                S_LA1:
                begin
                    state_reg <= S_LM2;
                end
                S_LA2:
                begin
                    dot_reg   <= add_res;
                    i_reg     <= i_reg + ONE_X;
                    k_reg     <= k_reg + ONE_P;
                    state_reg <= (i_reg + ONE_X == loop_end) ? S_FM : S_LRD;
                end
                S_FA:
                begin
                    kk_reg <= triangle_reg ? kk_reg + PCW'(n_reg - j_reg)
                                           : kk_reg + PCW'(j_reg) + ONE_P;
                    if (j_reg + ONE_X == n_reg)
                    begin
                        i_reg     <= '0;
                        state_reg <= S_ORD;
                    end
                    else
                    begin
                        j_reg     <= j_reg + ONE_X;
                        state_reg <= S_CRD;
                    end
                end
                S_ORD:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (can_load)
                    begin
                        out_valid_reg <= 1'b1;
                        out_index_reg <= RIDX_W'(i_reg);
                        out_bits_reg  <= y_rd_reg;
                        out_last_reg  <= (i_reg + ONE_X == n_reg);
                        if (i_reg + ONE_X == n_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            i_reg     <= i_reg + ONE_X;
                            state_reg <= S_ORD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_column_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CRD) |-> (j_reg < n_reg))
        else $error("column counter beyond matrix order");

    a_packed_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LRD) |-> (k_reg < PCW'(PD)))
        else $error("packed address beyond store");

    a_row_side: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LRD) |-> (triangle_reg ? (i_reg > j_reg) : (i_reg < j_reg)))
        else $error("sweep row on wrong side of diagonal");

    a_busy_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LA2) |=> !item.ready)
        else $error("beat taken during a run");
`endif

endmodule
